@@ rtl/lgc_pkg.sv @@
// Shared types, constants and color blend functions of the LED gradient crossfade unit.
// Has no dependencies; every other file of the block imports it.
package lgc_pkg;

    localparam int LED_COUNT_DEF  = 32;
    localparam int FADE_STEPS_DEF = 60;
    localparam int ORDER_DEPTH    = 64;

    localparam logic [6:0] LEN_MIN = 7'd6;
    localparam logic [6:0] LEN_MAX = 7'd64;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_APPLY = 2'd1;
    localparam logic [1:0] CMD_ORDER = 2'd2;
    localparam logic [1:0] CMD_FLAG  = 2'd3;

    localparam logic [1:0] MODE_GRAD   = 2'd0;
    localparam logic [1:0] MODE_MIRROR = 2'd1;
    localparam logic [1:0] MODE_AVG    = 2'd2;

    localparam logic [2:0] REG_COLOR_A      = 3'd0;
    localparam logic [2:0] REG_COLOR_B      = 3'd1;
    localparam logic [2:0] REG_PATTERN_MODE = 3'd2;
    localparam logic [2:0] REG_TARGET_LEVEL = 3'd3;
    localparam logic [2:0] REG_GRADIENT_LEN = 3'd4;

    localparam logic [23:0] COLOR_A_RST = 24'hFF0000;
    localparam logic [23:0] COLOR_B_RST = 24'h0000FF;
    localparam logic [1:0]  MODE_RST    = 2'd0;
    localparam logic [7:0]  LEVEL_RST   = 8'd255;
    localparam logic [6:0]  LEN_RST     = 7'd32;

    typedef struct packed {
        logic [1:0] command;
        logic [5:0] slot;
        logic [5:0] led_index;
        logic       flag_value;
    } t_in;

    typedef struct packed {
        logic [5:0]  led;
        logic [23:0] rgb;
        logic [7:0]  level;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [23:0] color_a;
        logic [23:0] color_b;
        logic [1:0]  pattern_mode;
        logic [7:0]  target_level;
        logic [6:0]  gradient_len;
    } t_cfg;

    typedef enum logic [3:0] {
        OP_TICK  = 4'b0001,
        OP_APPLY = 4'b0010,
        OP_ORDER = 4'b0100,
        OP_FLAG  = 4'b1000
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [5:0] slot;
        logic [5:0] led;
        logic       flag;
    } t_job;

    typedef struct packed {
        logic       start;
        logic [7:0] num;
        logic [7:0] den;
    } t_curve_req;

    typedef struct packed {
        logic        done;
        logic [16:0] s;
    } t_curve_rsp;

    // floor((a*65536 + (b-a)*s) / 65536), s in Q0.16 with 1.0 = 65536
    function automatic logic [7:0] mix_chan(logic [7:0] a, logic [7:0] b, logic [16:0] s);
        logic signed [8:0]  d;
        logic signed [17:0] ss;
        logic signed [26:0] p;
        logic signed [26:0] v;
        d  = $signed({1'b0, b}) - $signed({1'b0, a});
        ss = $signed({1'b0, s});
        p  = d * ss;
        v  = $signed({3'b000, a, 16'h0000}) + p;
        return v[23:16];
    endfunction

    function automatic logic [23:0] mix_rgb(logic [23:0] a, logic [23:0] b, logic [16:0] s);
        return {mix_chan(a[23:16], b[23:16], s),
                mix_chan(a[15:8], b[15:8], s),
                mix_chan(a[7:0], b[7:0], s)};
    endfunction

endpackage

@@ rtl/lgc_front.sv @@
// Front end of the crossfade unit: accepts requests, decodes the command, queues jobs.
// Depends on lgc_pkg.
module lgc_front #(
    parameter int LED_COUNT = lgc_pkg::LED_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lgc_pkg::t_in  i_in,
    input  logic          i_hold,
    output logic          o_job_valid,
    output lgc_pkg::t_job o_job,
    input  logic          i_job_pop
);
    import lgc_pkg::*;

    localparam int         QDEPTH = 2;
    localparam logic [6:0] LC7    = 7'(LED_COUNT);

    t_job       r_q [QDEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_job       job;
    logic       keep, accept, push, pop;

    always_comb begin
        job.slot = i_in.slot;
        job.led  = i_in.led_index;
        job.flag = i_in.flag_value;
        keep     = 1'b1;
        unique case (i_in.command)
            CMD_TICK:  job.op = OP_TICK;
            CMD_APPLY: job.op = OP_APPLY;
            CMD_ORDER: job.op = OP_ORDER;
            CMD_FLAG: begin
                job.op = OP_FLAG;
                // drop flag writes for LEDs that do not exist
                keep   = ({1'b0, i_in.led_index} < LC7);
            end
            default:   job.op = OP_TICK;
        endcase
    end

    assign o_in_stall  = (r_cnt == 2'(QDEPTH)) || i_hold;
    assign accept      = i_in_valid && !o_in_stall;
    assign push        = accept && keep;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];
    assign pop         = o_job_valid && i_job_pop;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

@@ rtl/lgc_curve.sv @@
// Easing unit: Q0.16 fraction num/den by restoring division, then smoothstep.
// Depends on lgc_pkg; one shared 17x18 multiplier.
module lgc_curve (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lgc_pkg::t_curve_req i_req,
    output lgc_pkg::t_curve_rsp o_rsp
);
    import lgc_pkg::*;

    localparam logic [4:0]  DIV_LAST = 5'd23;
    localparam logic [17:0] THREE_Q16 = 18'd196608;

    typedef enum logic [5:0] {
        C_IDLE = 6'b000001,
        C_DIV  = 6'b000010,
        C_SQ   = 6'b000100,
        C_LO   = 6'b001000,
        C_HI   = 6'b010000,
        C_FIN  = 6'b100000
    } t_cstate;

    t_cstate     r_state;
    logic [23:0] r_quo;
    logic [7:0]  r_rem;
    logic [7:0]  r_den;
    logic [4:0]  r_cnt;
    logic        r_zero;
    logic [16:0] r_t;
    logic [33:0] r_t2;
    logic [34:0] r_plo, r_phi;
    logic [16:0] r_s;
    logic        r_done;

    logic [8:0]  rem_sh, rem_diff;
    logic        ge;
    logic [16:0] t_val;
    logic [17:0] k;
    logic [16:0] mul_a;
    logic [17:0] mul_b;
    logic [34:0] prod;
    logic [52:0] sum;

    always_comb begin
        rem_sh   = {r_rem, r_quo[23]};
        rem_diff = rem_sh - {1'b0, r_den};
        ge       = (rem_sh >= {1'b0, r_den});
        t_val    = r_zero ? 17'h10000 : r_quo[16:0];
        k        = THREE_Q16 - {r_t, 1'b0};
        unique case (r_state)
            C_SQ: begin
                mul_a = t_val;
                mul_b = {1'b0, t_val};
            end
            C_LO: begin
                mul_a = r_t2[16:0];
                mul_b = k;
            end
            default: begin
                mul_a = r_t2[33:17];
                mul_b = k;
            end
        endcase
        prod = mul_a * mul_b;
        sum  = {1'b0, r_phi, 17'h00000} + {18'h00000, r_plo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_req.start) begin
                        r_zero  <= (i_req.den == 8'd0);
                        r_quo   <= {i_req.num, 16'h0000};
                        r_rem   <= 8'd0;
                        r_den   <= i_req.den;
                        r_cnt   <= 5'd0;
                        r_state <= (i_req.den == 8'd0) ? C_SQ : C_DIV;
                    end
                end
                C_DIV: begin
                    r_rem <= ge ? rem_diff[7:0] : rem_sh[7:0];
                    r_quo <= {r_quo[22:0], ge};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= C_SQ;
                    end
                end
                C_SQ: begin
                    r_t     <= t_val;
                    r_t2    <= prod[33:0];
                    r_state <= C_LO;
                end
                C_LO: begin
                    r_plo   <= prod;
                    r_state <= C_HI;
                end
                C_HI: begin
                    r_phi   <= prod;
                    r_state <= C_FIN;
                end
                C_FIN: begin
                    r_s     <= sum[48:32];
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.s    = r_s;

endmodule

@@ rtl/lgc_back.sv @@
// Back end of the crossfade unit: sequencer, color and order memories, result register.
// Depends on lgc_pkg; drives the easing unit lgc_curve through a request struct.
module lgc_back #(
    parameter int LED_COUNT  = lgc_pkg::LED_COUNT_DEF,
    parameter int FADE_STEPS = lgc_pkg::FADE_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lgc_pkg::t_cfg       i_cfg,
    input  logic                i_job_valid,
    input  lgc_pkg::t_job       i_job,
    output logic                o_job_pop,
    output logic                o_clearing,
    output lgc_pkg::t_curve_req o_curve_req,
    input  lgc_pkg::t_curve_rsp i_curve_rsp,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lgc_pkg::t_out       o_out
);
    import lgc_pkg::*;

    localparam int         LW   = $clog2(LED_COUNT);
    localparam logic [6:0] LC7  = 7'(LED_COUNT);
    localparam logic [6:0] LAST = 7'(LED_COUNT - 1);
    localparam logic [7:0] FS   = 8'(FADE_STEPS);
    localparam logic [6:0] OLAST = 7'(ORDER_DEPTH - 1);

    typedef enum logic [24:0] {
        S_CLEAR = 25'h0000001,
        S_IDLE  = 25'h0000002,
        T_CS    = 25'h0000004,
        T_CW    = 25'h0000008,
        T_RD    = 25'h0000010,
        T_MIX   = 25'h0000020,
        T_EMIT  = 25'h0000040,
        A_DISP  = 25'h0000080,
        A_SEL   = 25'h0000100,
        G_RD    = 25'h0000200,
        G_WR    = 25'h0000400,
        P_RD    = 25'h0000800,
        P_CAP   = 25'h0001000,
        P_CW    = 25'h0002000,
        P_MIX   = 25'h0004000,
        M_RD1   = 25'h0008000,
        M_RD2   = 25'h0010000,
        M_CAP   = 25'h0020000,
        M_CW    = 25'h0040000,
        M_MIX   = 25'h0080000,
        M_Q     = 25'h0100000,
        M_T1    = 25'h0200000,
        M_T2    = 25'h0400000,
        M_T3    = 25'h0800000,
        M_T4    = 25'h1000000
    } t_state;

    // memories
    logic [23:0] r_now_mem  [LED_COUNT];
    logic [23:0] r_from_mem [LED_COUNT];
    logic [23:0] r_goal_mem [LED_COUNT];
    logic [5:0]  r_ord_mem  [ORDER_DEPTH];
    logic [23:0] r_now_rd, r_from_rd, r_goal_rd;
    logic [5:0]  r_ord_rd;

    t_state                 r_state, n_state, r_ret, n_ret;
    logic [6:0]             r_i, n_i;
    logic [5:0]             r_gidx, n_gidx, r_p, n_p, r_q, n_q;
    logic [23:0]            r_gcolor, n_gcolor, r_new, n_new;
    logic                   r_mis, n_mis, r_snap, n_snap;
    logic [7:0]             r_fade, n_fade, r_now_lvl, n_now_lvl, r_from_lvl, n_from_lvl;
    logic [LED_COUNT-1:0]   r_mismatch, n_mismatch, r_flags, n_flags;
    logic                   r_out_valid;
    t_out                   r_out;

    logic              out_free, out_load;
    logic [LW-1:0]     led_ra, led_wa;
    logic              now_we, from_we, goal_we;
    logic [23:0]       now_wd, from_wd, goal_wd;
    logic [5:0]        ord_ra, ord_wa, ord_wd;
    logic              ord_we;
    logic [6:0]        n_len, h_len, i_next;
    logic [23:0]       avg_color, ab_mix, tick_mix;
    logic [16:0]       s;

    assign s        = i_curve_rsp.s;
    assign out_free = !r_out_valid || !i_out_stall;
    assign i_next   = r_i + 7'd1;

    always_comb begin
        if (i_cfg.gradient_len < LEN_MIN) begin
            n_len = LEN_MIN;
        end else if (i_cfg.gradient_len > LEN_MAX) begin
            n_len = LEN_MAX;
        end else begin
            n_len = i_cfg.gradient_len;
        end
        h_len = n_len >> 1;
        avg_color[23:16] = 8'((9'(i_cfg.color_a[23:16]) + 9'(i_cfg.color_b[23:16])) >> 1);
        avg_color[15:8]  = 8'((9'(i_cfg.color_a[15:8]) + 9'(i_cfg.color_b[15:8])) >> 1);
        avg_color[7:0]   = 8'((9'(i_cfg.color_a[7:0]) + 9'(i_cfg.color_b[7:0])) >> 1);
        ab_mix   = mix_rgb(i_cfg.color_a, i_cfg.color_b, s);
        tick_mix = mix_rgb(r_from_rd, r_goal_rd, s);
    end

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_i        = r_i;
        n_gidx     = r_gidx;
        n_gcolor   = r_gcolor;
        n_p        = r_p;
        n_q        = r_q;
        n_new      = r_new;
        n_mis      = r_mis;
        n_snap     = r_snap;
        n_fade     = r_fade;
        n_now_lvl  = r_now_lvl;
        n_from_lvl = r_from_lvl;
        n_mismatch = r_mismatch;
        n_flags    = r_flags;
        o_job_pop  = 1'b0;
        out_load   = 1'b0;
        led_ra     = r_i[LW-1:0];
        led_wa     = r_i[LW-1:0];
        now_we     = 1'b0;
        from_we    = 1'b0;
        goal_we    = 1'b0;
        now_wd     = r_new;
        from_wd    = r_new;
        goal_wd    = r_gcolor;
        ord_ra     = r_i[5:0];
        ord_we     = 1'b0;
        ord_wa     = r_i[5:0];
        ord_wd     = r_i[5:0];
        o_curve_req.start = 1'b0;
        o_curve_req.num   = {1'b0, r_i};
        o_curve_req.den   = {1'b0, n_len - 7'd1};

        unique case (r_state)
            S_CLEAR: begin
                // sweep memories to their reset contents
                ord_we = 1'b1;
                if (r_i < LC7) begin
                    now_we  = 1'b1;
                    from_we = 1'b1;
                    goal_we = 1'b1;
                    now_wd  = 24'h0;
                    from_wd = 24'h0;
                    goal_wd = 24'h0;
                end
                if (r_i == OLAST) begin
                    n_i     = 7'd0;
                    n_state = S_IDLE;
                end else begin
                    n_i = i_next;
                end
            end
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    unique case (i_job.op)
                        OP_ORDER: begin
                            ord_we = 1'b1;
                            ord_wa = i_job.slot;
                            ord_wd = i_job.led;
                        end
                        OP_FLAG: n_flags[i_job.led[LW-1:0]] = i_job.flag;
                        OP_APPLY: begin
                            n_from_lvl = r_now_lvl;
                            n_fade     = 8'd0;
                            n_i        = 7'd0;
                            n_state    = A_DISP;
                        end
                        OP_TICK: begin
                            n_i = 7'd0;
                            if (!(|r_mismatch) && r_now_lvl == i_cfg.target_level) begin
                                n_state = S_IDLE;
                            end else if (r_fade >= FS) begin
                                n_now_lvl  = i_cfg.target_level;
                                n_from_lvl = i_cfg.target_level;
                                n_fade     = 8'd0;
                                n_snap     = 1'b1;
                                n_state    = T_RD;
                            end else begin
                                n_snap  = 1'b0;
                                n_state = T_CS;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            T_CS: begin
                o_curve_req.start = 1'b1;
                o_curve_req.num   = r_fade;
                o_curve_req.den   = FS;
                n_state           = T_CW;
            end
            T_CW: begin
                if (i_curve_rsp.done) begin
                    n_now_lvl = mix_chan(r_from_lvl, i_cfg.target_level, s);
                    n_fade    = r_fade + 8'd1;
                    n_state   = T_RD;
                end
            end
            T_RD: begin
                n_state = T_MIX;
            end
            T_MIX: begin
                n_new   = r_snap ? r_goal_rd : tick_mix;
                n_mis   = !r_snap && (tick_mix != r_goal_rd);
                n_state = T_EMIT;
            end
            T_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    now_we   = 1'b1;
                    from_we  = r_snap;
                    n_mismatch[r_i[LW-1:0]] = r_mis;
                    if (r_i == LAST) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = i_next;
                        led_ra  = i_next[LW-1:0];
                        n_state = T_MIX;
                    end
                end
            end
            A_DISP: begin
                if (r_i == LC7) begin
                    n_state = A_SEL;
                end else begin
                    n_i = i_next;
                    if (r_flags[r_i[LW-1:0]]) begin
                        n_gidx   = r_i[5:0];
                        n_gcolor = i_cfg.color_a;
                        n_ret    = A_DISP;
                        n_state  = G_RD;
                    end
                end
            end
            A_SEL: begin
                n_i = 7'd0;
                unique case (i_cfg.pattern_mode)
                    MODE_GRAD, MODE_AVG: n_state = P_RD;
                    MODE_MIRROR:         n_state = M_RD1;
                    default:             n_state = S_IDLE;
                endcase
            end
            G_RD: begin
                led_ra = r_gidx[LW-1:0];
                if ({1'b0, r_gidx} >= LC7) begin
                    n_state = r_ret;
                end else begin
                    n_state = G_WR;
                end
            end
            G_WR: begin
                led_wa  = r_gidx[LW-1:0];
                from_we = 1'b1;
                goal_we = 1'b1;
                from_wd = r_now_rd;
                goal_wd = r_gcolor;
                n_mismatch[r_gidx[LW-1:0]] = (r_now_rd != r_gcolor);
                n_state = r_ret;
            end
            P_RD: begin
                if (r_i < n_len) begin
                    n_state = P_CAP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            P_CAP: begin
                n_p = r_ord_rd;
                if (i_cfg.pattern_mode == MODE_AVG) begin
                    n_i      = i_next;
                    n_gidx   = r_ord_rd;
                    n_gcolor = avg_color;
                    n_ret    = P_RD;
                    n_state  = G_RD;
                end else begin
                    o_curve_req.start = 1'b1;
                    n_state           = P_CW;
                end
            end
            P_CW: begin
                if (i_curve_rsp.done) begin
                    n_state = P_MIX;
                end
            end
            P_MIX: begin
                n_i      = i_next;
                n_gidx   = r_p;
                n_gcolor = ab_mix;
                n_ret    = P_RD;
                n_state  = G_RD;
            end
            M_RD1: begin
                if (i_next < h_len) begin
                    n_state = M_RD2;
                end else begin
                    n_state = M_T1;
                end
            end
            M_RD2: begin
                n_p     = r_ord_rd;
                ord_ra  = 6'(n_len - 7'd1 - r_i);
                n_state = M_CAP;
            end
            M_CAP: begin
                n_q = r_ord_rd;
                // skip the whole pair when either end is not a real LED
                if ({1'b0, r_p} >= LC7 || {1'b0, r_ord_rd} >= LC7) begin
                    n_i     = i_next;
                    n_state = M_RD1;
                end else begin
                    o_curve_req.start = 1'b1;
                    o_curve_req.den   = {1'b0, h_len - 7'd2};
                    n_state           = M_CW;
                end
            end
            M_CW: begin
                if (i_curve_rsp.done) begin
                    n_state = M_MIX;
                end
            end
            M_MIX: begin
                n_gidx   = r_p;
                n_gcolor = ab_mix;
                n_ret    = M_Q;
                n_state  = G_RD;
            end
            M_Q: begin
                n_i     = i_next;
                n_gidx  = r_q;
                n_ret   = M_RD1;
                n_state = G_RD;
            end
            M_T1: begin
                ord_ra  = 6'(h_len - 7'd1);
                n_state = M_T2;
            end
            M_T2: begin
                n_gidx   = r_ord_rd;
                n_gcolor = i_cfg.color_b;
                n_ret    = M_T3;
                n_state  = G_RD;
            end
            M_T3: begin
                ord_ra  = h_len[5:0];
                n_state = M_T4;
            end
            M_T4: begin
                n_gidx   = r_ord_rd;
                n_gcolor = i_cfg.color_b;
                n_ret    = S_IDLE;
                n_state  = G_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (now_we) begin
            r_now_mem[led_wa] <= now_wd;
        end
        if (from_we) begin
            r_from_mem[led_wa] <= from_wd;
        end
        if (goal_we) begin
            r_goal_mem[led_wa] <= goal_wd;
        end
        if (ord_we) begin
            r_ord_mem[ord_wa] <= ord_wd;
        end
        r_now_rd  <= r_now_mem[led_ra];
        r_from_rd <= r_from_mem[led_ra];
        r_goal_rd <= r_goal_mem[led_ra];
        r_ord_rd  <= r_ord_mem[ord_ra];
    end

    always_ff @(posedge i_clk) begin
        r_ret    <= n_ret;
        r_gidx   <= n_gidx;
        r_gcolor <= n_gcolor;
        r_p      <= n_p;
        r_q      <= n_q;
        r_new    <= n_new;
        r_mis    <= n_mis;
        r_snap   <= n_snap;
        if (out_load) begin
            r_out.led   <= r_i[5:0];
            r_out.rgb   <= r_new;
            r_out.level <= r_now_lvl;
            r_out.last  <= (r_i == LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_i         <= 7'd0;
            r_fade      <= 8'd0;
            r_now_lvl   <= 8'd0;
            r_from_lvl  <= 8'd0;
            r_mismatch  <= '0;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_fade      <= n_fade;
            r_now_lvl   <= n_now_lvl;
            r_from_lvl  <= n_from_lvl;
            r_mismatch  <= n_mismatch;
            r_flags     <= n_flags;
            r_out_valid <= out_load || (r_out_valid && i_out_stall);
        end
    end

    assign o_clearing  = (r_state == S_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ rtl/led_gradient_crossfade_unit.sv @@
// Top level of the LED gradient crossfade unit: configuration registers and wiring.
// Depends on lgc_pkg, lgc_front, lgc_curve and lgc_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries commands: tick,
//   apply settings, write order table slot, write display flag. A request is
//   taken on a rising edge with valid high and stall low; a two-entry queue
//   sits between the decode front and the execution back end.
//   Output channel (o_out_valid / i_out_stall / o_out) returns one result per
//   LED on an emitting tick, LED 0 first, last set on LED LED_COUNT-1.
//   Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_idx
//   (color_a, color_b, pattern_mode, target_level, gradient_len); write only
//   while the unit is idle.
//   Sequencing: a fading tick passes the easing unit (24-step divider plus
//   three multiply steps) and then emits each LED in turn; a snapping tick
//   skips the easing unit. Apply walks all LEDs, then, in modes 0 to 2, the
//   gradient slots, with one easing pass for each slot in mode 0 and for
//   each slot pair in mode 1. Order and flag writes complete in the idle
//   state. The back end handles one command at a time.
//   Reset: a clearing pass fills the memories; stall is held high.
//   A stalled output holds its result and the back end waits on it.
module led_gradient_crossfade_unit #(
    parameter int LED_COUNT  = lgc_pkg::LED_COUNT_DEF,
    parameter int FADE_STEPS = lgc_pkg::FADE_STEPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lgc_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lgc_pkg::t_out o_out,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [23:0]   i_cfg_wdata
);
    import lgc_pkg::*;

    t_cfg       r_cfg;
    logic       job_valid, job_pop, clearing;
    t_job       job;
    t_curve_req curve_req;
    t_curve_rsp curve_rsp;

    // configuration registers; writes to unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color_a      <= COLOR_A_RST;
            r_cfg.color_b      <= COLOR_B_RST;
            r_cfg.pattern_mode <= MODE_RST;
            r_cfg.target_level <= LEVEL_RST;
            r_cfg.gradient_len <= LEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COLOR_A:      r_cfg.color_a      <= i_cfg_wdata;
                REG_COLOR_B:      r_cfg.color_b      <= i_cfg_wdata;
                REG_PATTERN_MODE: r_cfg.pattern_mode <= i_cfg_wdata[1:0];
                REG_TARGET_LEVEL: r_cfg.target_level <= i_cfg_wdata[7:0];
                REG_GRADIENT_LEN: r_cfg.gradient_len <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // decode and queue requests; hold off during the clearing pass
    lgc_front #(
        .LED_COUNT(LED_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_hold      (clearing),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    // shared easing unit: fraction then smoothstep
    lgc_curve u_curve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (curve_req),
        .o_rsp   (curve_rsp)
    );

    // execution: goal building, fade steps, result register
    lgc_back #(
        .LED_COUNT  (LED_COUNT),
        .FADE_STEPS (FADE_STEPS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_clearing  (clearing),
        .o_curve_req (curve_req),
        .i_curve_rsp (curve_rsp),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

@@ rtl/lgc_checker.sv @@
// Port-level checks for the LED gradient crossfade unit, bound to the top level.
// Depends on lgc_pkg and led_gradient_crossfade_unit.
module lgc_checker #(
    parameter int LED_COUNT = lgc_pkg::LED_COUNT_DEF
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input lgc_pkg::t_out o_out
);
    import lgc_pkg::*;

    localparam logic [5:0] LAST_LED = 6'(LED_COUNT - 1);

    // last marks exactly the final LED of a run
    a_last_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.last == (o_out.led == LAST_LED)))
        else $error("last flag does not match final LED");

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    // one level for the whole run
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out.last |=>
            !o_out_valid || (o_out.level == $past(o_out.level)))
        else $error("level changed within a run");

    // input held off right after reset while memories clear
    a_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input accepted during clearing pass");

endmodule

bind led_gradient_crossfade_unit lgc_checker #(
    .LED_COUNT(LED_COUNT)
) u_lgc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

@@ tb/led_gradient_crossfade_unit_test.sv @@
// Self-checking testbench for the LED gradient crossfade unit: directed and random
// requests with random idling on both channels. Depends on lgc_pkg and the unit RTL.
module led_gradient_crossfade_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lgc_pkg::*;

    localparam int NUM_LEDS   = LED_COUNT_DEF;
    localparam int NUM_STEPS  = FADE_STEPS_DEF;
    localparam int Q_ONE      = 65536;
    localparam int CYCLE_MAX  = 5000000;
    localparam int SETTLE_CYC = 8000;   // covers three queued applies walking 64 slots each

    // Predicts the LED stream of every tick and checks the emitted results against it.
    class crossfade_scoreboard;
        bit [23:0] now_rgb[NUM_LEDS];
        bit [23:0] start_rgb[NUM_LEDS];
        bit [23:0] goal_rgb[NUM_LEDS];
        bit [5:0]  order_map[ORDER_DEPTH];
        bit        is_display[NUM_LEDS];
        int        step_cnt;
        bit [7:0]  now_lvl, start_lvl;
        bit [23:0] col_a, col_b;
        bit [1:0]  mode;
        bit [7:0]  lvl_goal;
        bit [6:0]  grad_len;
        t_out      pending_leds[$];
        int        errors;

        function new();
            for (int i = 0; i < NUM_LEDS; i++) begin
                now_rgb[i] = '0; start_rgb[i] = '0; goal_rgb[i] = '0; is_display[i] = 0;
            end
            for (int i = 0; i < ORDER_DEPTH; i++) order_map[i] = i[5:0];
            step_cnt = 0; now_lvl = 0; start_lvl = 0; errors = 0;
            col_a = COLOR_A_RST; col_b = COLOR_B_RST; mode = MODE_RST;
            lvl_goal = LEVEL_RST; grad_len = LEN_RST;
        endfunction

        function void write_reg(bit [2:0] idx, bit [23:0] data);
            case (idx)
                REG_COLOR_A:      col_a = data;
                REG_COLOR_B:      col_b = data;
                REG_PATTERN_MODE: mode = data[1:0];
                REG_TARGET_LEVEL: lvl_goal = data[7:0];
                REG_GRADIENT_LEN: grad_len = data[6:0];
                default: ;
            endcase
        endfunction

        function longint ratio_q16(longint num, longint den);
            if (den == 0) return Q_ONE;
            return (num * Q_ONE) / den;
        endfunction

        function longint ease_q16(longint t);
            longint v;
            v = 3 * t * t * Q_ONE - 2 * t * t * t;
            if (v < 0) v = 0;
            return v >>> 32;
        endfunction

        function bit [7:0] blend8(longint a, longint b, longint s);
            longint v;
            v = a * Q_ONE + (b - a) * s;
            if (v < 0) v = 0;
            return v[23:16];
        endfunction

        function bit [23:0] blend24(bit [23:0] a, bit [23:0] b, longint s);
            return {blend8(a[23:16], b[23:16], s), blend8(a[15:8], b[15:8], s),
                    blend8(a[7:0], b[7:0], s)};
        endfunction

        function void aim(int idx, bit [23:0] c);
            if (idx >= NUM_LEDS) return;
            start_rgb[idx] = now_rgb[idx];
            goal_rgb[idx]  = c;
        endfunction

        function void build_targets();
            int n, h, p, q;
            bit [23:0] c;
            n = grad_len;
            if (n < 6) n = 6;
            if (n > ORDER_DEPTH) n = ORDER_DEPTH;
            for (int i = 0; i < NUM_LEDS; i++)
                if (is_display[i]) aim(i, col_a);
            case (mode)
                MODE_GRAD:
                    for (int i = 0; i < n; i++)
                        aim(order_map[i], blend24(col_a, col_b, ease_q16(ratio_q16(i, n - 1))));
                MODE_MIRROR: begin
                    h = n / 2;
                    for (int i = 0; i + 1 < h; i++) begin
                        p = order_map[i];
                        q = order_map[n - 1 - i];
                        if (p < NUM_LEDS && q < NUM_LEDS) begin
                            c = blend24(col_a, col_b, ease_q16(ratio_q16(i, h - 2)));
                            aim(p, c);
                            aim(q, c);
                        end
                    end
                    aim(order_map[h - 1], col_b);
                    aim(order_map[h], col_b);
                end
                MODE_AVG: begin
                    c = {8'((int'(col_a[23:16]) + col_b[23:16]) / 2),
                         8'((int'(col_a[15:8]) + col_b[15:8]) / 2),
                         8'((int'(col_a[7:0]) + col_b[7:0]) / 2)};
                    for (int i = 0; i < n; i++) aim(order_map[i], c);
                end
                default: ;  // unused mode: displays only
            endcase
        endfunction

        function void push_frame();
            t_out r;
            for (int i = 0; i < NUM_LEDS; i++) begin
                r.led = i[5:0]; r.rgb = now_rgb[i]; r.level = now_lvl;
                r.last = (i == NUM_LEDS - 1);
                pending_leds.push_back(r);
            end
        endfunction

        function void note_request(t_in req);
            bit settled;
            longint s;
            case (req.command)
                CMD_APPLY: begin
                    start_lvl = now_lvl;
                    step_cnt = 0;
                    build_targets();
                end
                CMD_ORDER: order_map[req.slot] = req.led_index;
                CMD_FLAG:  if (req.led_index < NUM_LEDS) is_display[req.led_index] = req.flag_value;
                default: begin
                    settled = (now_lvl == lvl_goal);
                    for (int i = 0; i < NUM_LEDS; i++)
                        if (now_rgb[i] != goal_rgb[i]) settled = 0;
                    if (settled) return;  // nothing to fade: stay silent
                    if (step_cnt >= NUM_STEPS) begin
                        // snap to the targets at the end of the fade
                        step_cnt = 0; now_lvl = lvl_goal; start_lvl = lvl_goal;
                        for (int i = 0; i < NUM_LEDS; i++) begin
                            now_rgb[i] = goal_rgb[i]; start_rgb[i] = goal_rgb[i];
                        end
                    end else begin
                        s = ease_q16(ratio_q16(step_cnt, NUM_STEPS));
                        for (int i = 0; i < NUM_LEDS; i++)
                            now_rgb[i] = blend24(start_rgb[i], goal_rgb[i], s);
                        now_lvl = blend8(start_lvl, lvl_goal, s);
                        step_cnt = (step_cnt + 1) & 8'hFF;
                    end
                    push_frame();
                end
            endcase
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending_leds.size() == 0) begin
                $display("%0t: unexpected result led %0d rgb %h", $time, got.led, got.rgb);
                errors++;
                return;
            end
            want = pending_leds.pop_front();
            if (got.led != want.led) begin
                $display("%0t: led expected %0d actual %0d", $time, want.led, got.led);
                errors++;
            end
            if (got.rgb != want.rgb) begin
                $display("%0t: rgb of led %0d expected %h actual %h",
                         $time, want.led, want.rgb, got.rgb);
                errors++;
            end
            if (got.level != want.level) begin
                $display("%0t: level of led %0d expected %0d actual %0d",
                         $time, want.led, want.level, got.level);
                errors++;
            end
            if (got.last != want.last) begin
                $display("%0t: last of led %0d expected %0d actual %0d",
                         $time, want.led, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [23:0] i_cfg_wdata;

    crossfade_scoreboard sb = new();
    int cycles;
    bit send_calm;   // when set the sender offers back-to-back

    led_gradient_crossfade_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort the run if it drags on far beyond the slowest legal schedule.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: draw a hold per result, with calm stretches, and one long hold-off
    // during the long fade so the internal queue fills and the input stalls.
    initial begin
        int hold, taken;
        bit calm;
        hold = 0; taken = 0; calm = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                sb.check_result(o_out);
                taken++;
                if (taken % 64 == 0) calm = ($urandom_range(0, 2) == 0);
                if (taken == 400) hold = 600;
                else hold = calm ? 0 : $urandom_range(0, 18);
            end else if (hold > 0) begin
                hold--;
            end
            i_out_stall <= (hold > 0);
        end
    end

    function automatic t_in make_req(bit [1:0] cmd, bit [5:0] slot, bit [5:0] led, bit flag);
        t_in r;
        r.command = cmd; r.slot = slot; r.led_index = led; r.flag_value = flag;
        return r;
    endfunction

    // Offer one request, hold it until taken, then idle for a drawn gap.
    task automatic send_req(t_in req);
        int gap;
        i_in       <= req;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(req);
        gap = send_calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid, drain every expected result and let the back end finish.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_leds.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(bit [2:0] idx, bit [23:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    function automatic bit [23:0] pick_color();
        case ($urandom_range(0, 3))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_config();
        int pick;
        write_reg(REG_COLOR_A, pick_color());
        write_reg(REG_COLOR_B, pick_color());
        write_reg(REG_PATTERN_MODE, 24'($urandom_range(0, 3)));
        pick = $urandom_range(0, 3);
        write_reg(REG_TARGET_LEVEL, pick == 0 ? 24'd0 : pick == 1 ? 24'd255
                                                : 24'($urandom_range(0, 255)));
        pick = $urandom_range(0, 4);
        write_reg(REG_GRADIENT_LEN, pick == 0 ? 24'(LEN_MIN) : pick == 1 ? 24'(LEN_MAX)
                                                : 24'($urandom_range(0, 127)));
    endtask

    function automatic t_in random_req();
        int w;
        bit [5:0] led;
        w = $urandom_range(0, 99);
        led = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(0, NUM_LEDS - 1));
        if (w < 62) return make_req(CMD_TICK, 6'($urandom), 6'($urandom), 1'($urandom));
        if (w < 72) return make_req(CMD_APPLY, 6'($urandom), 6'($urandom), 1'($urandom));
        if (w < 86) return make_req(CMD_ORDER, 6'($urandom_range(0, 63)), led, 1'($urandom));
        return make_req(CMD_FLAG, 6'($urandom), led, 1'($urandom));
    endfunction

    initial begin
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_in = '0; i_out_stall = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_wdata = '0;
        cycles = 0; send_calm = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // hold off until the clearing pass after reset releases the input
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);

        // Directed: reset settings, display flags incl. out-of-range LED, order edge entries.
        send_req(make_req(CMD_TICK, 6'h00, 6'h00, 1'b0));
        send_req(make_req(CMD_FLAG, 6'h00, 6'd0, 1'b1));
        send_req(make_req(CMD_FLAG, 6'h3F, 6'd63, 1'b1));
        send_req(make_req(CMD_FLAG, 6'h15, 6'd31, 1'b1));
        send_req(make_req(CMD_ORDER, 6'd63, 6'd63, 1'b1));
        send_req(make_req(CMD_ORDER, 6'd2, 6'd40, 1'b0));
        send_req(make_req(CMD_ORDER, 6'd0, 6'd31, 1'b0));
        send_req(make_req(CMD_APPLY, 6'h2A, 6'h15, 1'b1));
        send_req(make_req(CMD_TICK, 6'h3F, 6'h3F, 1'b1));
        send_req(make_req(CMD_TICK, 6'h00, 6'h00, 1'b0));
        drain();

        // Mirrored gradient at the shortest length, extreme colors, level 0.
        write_reg(REG_COLOR_A, 24'h000000);
        write_reg(REG_COLOR_B, 24'hFFFFFF);
        write_reg(REG_PATTERN_MODE, 24'(MODE_MIRROR));
        write_reg(REG_TARGET_LEVEL, 24'd0);
        write_reg(REG_GRADIENT_LEN, 24'(LEN_MIN));
        send_req(make_req(CMD_ORDER, 6'd1, 6'd50, 1'b0));
        send_req(make_req(CMD_APPLY, 6'h00, 6'h00, 1'b0));
        send_req(make_req(CMD_TICK, 6'h00, 6'h00, 1'b0));
        send_req(make_req(CMD_TICK, 6'h00, 6'h00, 1'b0));
        drain();

        // Unused mode with a length below range, then average with one above range.
        write_reg(REG_PATTERN_MODE, 24'd3);
        write_reg(REG_GRADIENT_LEN, 24'd0);
        write_reg(REG_TARGET_LEVEL, 24'd255);
        send_req(make_req(CMD_APPLY, 6'h00, 6'h00, 1'b0));
        send_req(make_req(CMD_TICK, 6'h00, 6'h00, 1'b0));
        drain();
        write_reg(REG_PATTERN_MODE, 24'(MODE_AVG));
        write_reg(REG_GRADIENT_LEN, 24'd127);
        send_req(make_req(CMD_APPLY, 6'h00, 6'h00, 1'b0));
        send_req(make_req(CMD_TICK, 6'h00, 6'h00, 1'b0));
        drain();

        // Full fade: run past the fade length so the snap and the silent ticks both occur.
        random_config();
        send_req(make_req(CMD_APPLY, 6'($urandom), 6'($urandom), 1'($urandom)));
        for (int k = 0; k < 65; k++) begin
            if (k % 20 == 0) send_calm = ($urandom_range(0, 2) == 0);
            send_req(make_req(CMD_TICK, 6'($urandom), 6'($urandom), 1'($urandom)));
        end
        drain();

        // Random phases: fresh settings each time, mostly ticks between applies.
        for (int ph = 0; ph < 5; ph++) begin
            random_config();
            for (int k = 0; k < 50; k++) begin
                if (k % 16 == 0) send_calm = ($urandom_range(0, 2) == 0);
                send_req(random_req());
            end
            drain();
        end

        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_leds.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
